// ===== sv/cfpq_pkg.sv =====
// Shared types, constants and the frame packing function for the CAN frame packer.
`timescale 1ns / 1ps

package cfpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam int unsigned ID_W   = 29;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CNT_IN_W = 4;

  // Identifier bit positions
  localparam int unsigned SRC_SHIFT    = 22;
  localparam int unsigned DST_SHIFT    = 15;
  localparam int unsigned FUNC_SHIFT   = 7;
  localparam int unsigned TOTAL_SHIFT  = 4;
  localparam int unsigned OBJ_HI_SHIFT = 9;

  // Stream widths
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 104;
  localparam int unsigned M_TUSER_W = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_CODE     = 1'b1;

  localparam logic [CODE_W-1:0] EMERGENCY_CODE_RST = 8'd35;
  localparam logic [CODE_W-1:0] REPLY_CODE_RST     = 8'd33;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADLEN = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // One queued frame
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } frame_t;

  // Ring occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  function automatic frame_t pack_frame(
    input logic [6:0]  src,
    input logic [6:0]  dst,
    input logic [7:0]  fc,
    input logic [2:0]  tot,
    input logic [2:0]  part,
    input logic [9:0]  obj,
    input logic [4:0]  och,
    input logic [9:0]  attr,
    input logic [6:0]  ach,
    input logic [31:0] vals,
    input logic [3:0]  cnt
  );
    frame_t      f;
    logic [31:0] vmask;
    begin
      f.id = {src, dst, fc, tot, part, obj[OBJ_HI_SHIFT]};
      case (cnt)
        4'd1:    vmask = 32'h0000_00FF;
        4'd2:    vmask = 32'h0000_FFFF;
        4'd3:    vmask = 32'h00FF_FFFF;
        default: vmask = 32'hFFFF_FFFF;
      endcase
      f.data = {vals & vmask,
                attr[0], ach,
                attr[8:1],
                obj[0], och, 1'b0, attr[OBJ_HI_SHIFT],
                obj[8:1]};
      f.len = LEN_W'(cnt + 4'd4);
      return f;
    end
  endfunction

endpackage

// ===== sv/cfpq_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module cfpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cfpq_ring.sv =====
// Frame ring buffer: head/tail pointers, occupancy count and frame storage.
`timescale 1ns / 1ps

module cfpq_ring
  import cfpq_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_t     wdata_i,
  input  logic       pop_i,
  output frame_t     rdata_o,
  output ring_stat_t stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
    end
    if (pop_i) begin
      head_d = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  cfpq_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (tail_q),
    .wdata_i (wdata_i),
    .re_i    (pop_i),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

endmodule

// ===== sv/can_frame_packer_priority_queues_core.sv =====
// Top level of the CAN frame packer with emergency and normal frame queues.
//
// Input stream (s_axis_*): tuser selects the request. 0 packs the fields in
// tdata into a 29-bit extended identifier plus an 8-byte payload and queues
// it (emergency ring when func_code matches the emergency code, else normal
// ring). 1 is a send tick that pops one frame, emergency ring first.
// Output stream (m_axis_*): exactly one result transfer per input transfer,
// in order: status, and for a send tick the frame itself.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 emergency code, 1 reply code); write only while idle.
// Path: decode and ring access, then the result register, which drives
// m_axis. Throughput is one transfer per cycle while m_axis_tready is
// held high, carried by the ring update at acceptance and the registered
// read of the ring RAM.
// Reset clears both rings to empty and loads the default codes (35, 33).
// A stalled receiver holds the result register; the middle stage then
// fills and s_axis_tready drops until m_axis_tready returns.
`timescale 1ns / 1ps

module can_frame_packer_priority_queues_core
  import cfpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CODE_W-1:0]    cfg_wdata_i,
  // Request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, low bit up: source_id(7) dest_id(7) func_code(8) total_parts(3)
  // part_number(3) object_id(10) object_channel(5) attribute_id(10)
  // attribute_channel(7) values(32) value_count(4)
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: kind(1)
  input  logic                 s_axis_tuser,
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, low bit up: status(2) frame_id(29) frame_length(4) frame_data(64)
  // zero pad(5)
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser, low bit up: frame_valid(1) from_emergency(1)
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  // Config registers
  logic [CODE_W-1:0] emerg_code_q, reply_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emerg_code_q <= EMERGENCY_CODE_RST;
      reply_code_q <= REPLY_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EMERGENCY_CODE: emerg_code_q <= cfg_wdata_i;
        REG_REPLY_CODE:     reply_code_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request field unpacking
  logic [6:0]  src, dst, ach;
  logic [7:0]  fc;
  logic [2:0]  tot, part;
  logic [9:0]  obj, attr;
  logic [4:0]  och;
  logic [31:0] vals;
  logic [3:0]  cnt;

  assign src  = s_axis_tdata[6:0];
  assign dst  = s_axis_tdata[13:7];
  assign fc   = s_axis_tdata[21:14];
  assign tot  = s_axis_tdata[24:22];
  assign part = s_axis_tdata[27:25];
  assign obj  = s_axis_tdata[37:28];
  assign och  = s_axis_tdata[42:38];
  assign attr = s_axis_tdata[52:43];
  assign ach  = s_axis_tdata[59:53];
  assign vals = s_axis_tdata[91:60];
  assign cnt  = s_axis_tdata[95:92];

  // Pipeline handshake: stage 1 (ring access) then output register
  logic    p1_valid_q, p1_valid_d;
  status_e p1_status_q, p1_status_d;
  logic    p1_fvalid_q, p1_fvalid_d;
  logic    p1_emerg_q, p1_emerg_d;
  logic    out_valid_q;
  logic    out_load;
  logic    accept;

  assign out_load      = p1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !p1_valid_q || out_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode
  ring_stat_t u_stat, n_stat;
  frame_t     new_frame, u_rdata, n_rdata;
  logic       urgent, len_ok, ring_full;
  logic       push_u, push_n, pop_u, pop_n;

  assign urgent    = (fc == emerg_code_q);
  assign len_ok    = (cnt >= 4'd2 && cnt <= 4'd4) ||
                     (cnt == 4'd1 && !urgent && fc == reply_code_q);
  assign ring_full = urgent ? u_stat.full : n_stat.full;
  assign new_frame = pack_frame(src, dst, fc, tot, part, obj, och, attr, ach, vals, cnt);

  assign push_u = accept && !s_axis_tuser && len_ok && !ring_full && urgent;
  assign push_n = accept && !s_axis_tuser && len_ok && !ring_full && !urgent;
  assign pop_u  = accept && s_axis_tuser && !u_stat.empty;
  assign pop_n  = accept && s_axis_tuser && u_stat.empty && !n_stat.empty;

  always_comb begin
    p1_valid_d  = p1_valid_q;
    p1_status_d = p1_status_q;
    p1_fvalid_d = p1_fvalid_q;
    p1_emerg_d  = p1_emerg_q;
    if (out_load) begin
      p1_valid_d = 1'b0;
    end
    if (accept) begin
      p1_valid_d  = 1'b1;
      p1_fvalid_d = pop_u || pop_n;
      p1_emerg_d  = pop_u;
      if (s_axis_tuser) begin
        p1_status_d = (pop_u || pop_n) ? ST_OK : ST_EMPTY;
      end else if (!len_ok) begin
        p1_status_d = ST_BADLEN;
      end else if (ring_full) begin
        p1_status_d = ST_FULL;
      end else begin
        p1_status_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= p1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_status_q <= p1_status_d;
    p1_fvalid_q <= p1_fvalid_d;
    p1_emerg_q  <= p1_emerg_d;
  end

  cfpq_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_urgent_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_u),
    .wdata_i (new_frame),
    .pop_i   (pop_u),
    .rdata_o (u_rdata),
    .stat_o  (u_stat)
  );

  cfpq_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_normal_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_n),
    .wdata_i (new_frame),
    .pop_i   (pop_n),
    .rdata_o (n_rdata),
    .stat_o  (n_stat)
  );

  // Frame from the ring read port; zero when nothing was popped
  frame_t p1_frame;

  always_comb begin
    if (!p1_fvalid_q) begin
      p1_frame = '0;
    end else if (p1_emerg_q) begin
      p1_frame = u_rdata;
    end else begin
      p1_frame = n_rdata;
    end
  end

  // Output register
  status_e    out_status_q;
  frame_t     out_frame_q;
  logic       out_fvalid_q, out_emerg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= p1_status_q;
      out_frame_q  <= p1_frame;
      out_fvalid_q <= p1_fvalid_q;
      out_emerg_q  <= p1_emerg_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_frame_q.data, out_frame_q.len, out_frame_q.id,
                          out_status_q};
  assign m_axis_tuser  = {out_emerg_q, out_fvalid_q};

`ifndef ASSERT_OFF
  // At most one ring operation per accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({push_u, push_n, pop_u, pop_n}))
    else $error("more than one ring operation in a cycle");

  // Normal ring is popped only when the emergency ring is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_n |-> u_stat.empty)
    else $error("normal frame sent ahead of emergency frame");

  // An accepted request always reaches the ring access stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> p1_valid_q)
    else $error("accepted request lost");

  // A sent frame always carries status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (out_status_q == ST_OK))
    else $error("frame sent with non-ok status");
`endif

endmodule

// ===== bench/can_frame_packer_priority_queues_core_tb.sv =====
// Self-checking bench for the CAN frame packer with emergency and normal queues.
`timescale 1ns / 1ps

module can_frame_packer_priority_queues_core_tb;
  import cfpq_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NORMAL_RING = 0;
  localparam int unsigned URGENT_RING = 1;
  localparam logic        KIND_PACK   = 1'b0;
  localparam logic        KIND_SEND   = 1'b1;

  // One request as it travels on s_axis
  typedef struct {
    logic        kind;
    logic [6:0]  src;
    logic [6:0]  dst;
    logic [7:0]  fc;
    logic [2:0]  tot;
    logic [2:0]  part;
    logic [9:0]  obj;
    logic [4:0]  och;
    logic [9:0]  attr;
    logic [6:0]  ach;
    logic [31:0] vals;
    logic [3:0]  cnt;
  } request_t;

  // One result as it travels on m_axis
  typedef struct {
    status_e            status;
    logic               frame_valid;
    logic               from_emergency;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
  } frame_result_t;

  // Tracks both frame rings and the queue of results still owed by the block.
  class FrameQueueScoreboard;
    logic [CODE_W-1:0] urgent_fc;
    logic [CODE_W-1:0] reply_fc;
    logic [ID_W-1:0]   ring_id   [2][DEPTH];
    logic [LEN_W-1:0]  ring_len  [2][DEPTH];
    logic [DATA_W-1:0] ring_data [2][DEPTH];
    int unsigned       head [2];
    int unsigned       tail [2];
    int unsigned       fill [2];
    frame_result_t     owed_q [$];
    int unsigned       mismatches;

    function new();
      urgent_fc  = EMERGENCY_CODE_RST;
      reply_fc   = REPLY_CODE_RST;
      head       = '{0, 0};
      tail       = '{0, 0};
      fill       = '{0, 0};
      mismatches = 0;
    endfunction

    function void set_code(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
      if (idx == REG_EMERGENCY_CODE) urgent_fc = value;
      else reply_fc = value;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Predict the result of one accepted request and queue it
    function void note_request(request_t r);
      frame_result_t res;
      int unsigned   ring;
      logic          urgent;
      logic          len_ok;
      logic [31:0]   vmask;
      res = '{status: ST_OK, frame_valid: 1'b0, from_emergency: 1'b0,
              id: '0, len: '0, data: '0};
      if (r.kind == KIND_PACK) begin
        urgent = (r.fc == urgent_fc);
        // one value byte only for the reply code, and never on the emergency path
        len_ok = (r.cnt >= 2 && r.cnt <= 4) || (r.cnt == 1 && !urgent && r.fc == reply_fc);
        ring   = urgent ? URGENT_RING : NORMAL_RING;
        if (!len_ok) begin
          res.status = ST_BADLEN;
        end else if (fill[ring] >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          vmask = (r.cnt >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * r.cnt)) - 32'd1);
          ring_id[ring][tail[ring]] = (ID_W'(r.src) << SRC_SHIFT) | (ID_W'(r.dst) << DST_SHIFT)
                                    | (ID_W'(r.fc) << FUNC_SHIFT) | (ID_W'(r.tot) << TOTAL_SHIFT)
                                    | (ID_W'(r.part) << 1) | ID_W'(r.obj >> OBJ_HI_SHIFT);
          ring_data[ring][tail[ring]] = {r.vals & vmask,
                                         r.attr[0], r.ach,
                                         r.attr[8:1],
                                         r.obj[0], r.och, 1'b0, r.attr[9],
                                         r.obj[8:1]};
          ring_len[ring][tail[ring]] = r.cnt + 4'd4;
          tail[ring] = (tail[ring] + 1) % DEPTH;
          fill[ring]++;
        end
      end else begin
        // send tick: emergency ring drains first
        if (fill[URGENT_RING] > 0) ring = URGENT_RING;
        else ring = NORMAL_RING;
        if (fill[ring] == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.frame_valid    = 1'b1;
          res.from_emergency = (ring == URGENT_RING);
          res.id             = ring_id[ring][head[ring]];
          res.len            = ring_len[ring][head[ring]];
          res.data           = ring_data[ring][head[ring]];
          head[ring] = (head[ring] + 1) % DEPTH;
          fill[ring]--;
        end
      end
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      frame_result_t exp_res;
      frame_result_t act;
      act.status         = status_e'(tdata[1:0]);
      act.id             = tdata[30:2];
      act.len            = tdata[34:31];
      act.data           = tdata[98:35];
      act.frame_valid    = tuser[0];
      act.from_emergency = tuser[1];
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing outstanding: status %s",
                   $realtime, act.status.name());
        return;
      end
      exp_res = owed_q.pop_front();
      if (act.status != exp_res.status || act.frame_valid != exp_res.frame_valid ||
          act.from_emergency != exp_res.from_emergency || act.id != exp_res.id ||
          act.len != exp_res.len || act.data != exp_res.data) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp st=%s fv=%0b em=%0b id=%h len=%0d data=%h",
                   $realtime, exp_res.status.name(), exp_res.frame_valid,
                   exp_res.from_emergency, exp_res.id, exp_res.len, exp_res.data);
          $display("%0t:          act st=%s fv=%0b em=%0b id=%h len=%0d data=%h",
                   $realtime, act.status.name(), act.frame_valid,
                   act.from_emergency, act.id, act.len, act.data);
        end
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CODE_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // tdata, low bit up: source_id(7) dest_id(7) func_code(8) total_parts(3)
  // part_number(3) object_id(10) object_channel(5) attribute_id(10)
  // attribute_channel(7) values(32) value_count(4)
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // tuser: kind(1)
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // tdata, low bit up: status(2) frame_id(29) frame_length(4) frame_data(64) zero pad(5)
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // tuser, low bit up: frame_valid(1) from_emergency(1)
  logic [M_TUSER_W-1:0] m_axis_tuser;

  FrameQueueScoreboard frame_sb = new();
  bit                  quiet_run = 1'b0;  // no idling on either side while set
  int unsigned         cycle_cnt = 0;

  can_frame_packer_priority_queues_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: stall now and then unless a quiet stretch is running
  always @(negedge clk_i) begin
    m_axis_tready <= quiet_run ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // Result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      frame_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Request with random payload fields around the given kind, code and count
  function automatic request_t build_request(logic kind, logic [7:0] fc, logic [3:0] cnt);
    request_t r;
    r.kind = kind;
    r.src  = 7'($urandom_range(127));
    r.dst  = 7'($urandom_range(127));
    r.fc   = fc;
    r.tot  = 3'($urandom_range(7));
    r.part = 3'($urandom_range(7));
    r.obj  = 10'($urandom_range(1023));
    r.och  = 5'($urandom_range(31));
    r.attr = 10'($urandom_range(1023));
    r.ach  = 7'($urandom_range(127));
    r.vals = $urandom;
    r.cnt  = cnt;
    return r;
  endfunction

  // Random request: codes mostly hit the configured ones, counts mostly legal
  function automatic request_t random_request(int unsigned send_pct);
    logic [7:0] fc;
    logic [3:0] cnt;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3)      fc = frame_sb.urgent_fc;
    else if (pick < 5) fc = frame_sb.reply_fc;
    else               fc = 8'($urandom_range(255));
    if ($urandom_range(99) < 80) cnt = 4'($urandom_range(4, 1));
    else                         cnt = 4'($urandom_range(15));
    return build_request(($urandom_range(99) < send_pct) ? KIND_SEND : KIND_PACK, fc, cnt);
  endfunction

  // Drive one request; entered and left at a falling edge
  task automatic push_request(request_t r);
    if (!quiet_run && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {r.cnt, r.vals, r.ach, r.attr, r.och, r.obj,
                      r.part, r.tot, r.fc, r.dst, r.src};
    do @(posedge clk_i); while (!s_axis_tready);
    frame_sb.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned n, int unsigned send_pct);
    repeat (n) push_request(random_request(send_pct));
    s_axis_tvalid <= 1'b0;
  endtask

  // Register write, only once every owed result has been seen
  task automatic write_code(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
    while (frame_sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    frame_sb.set_code(idx, value);
  endtask

  initial begin
    request_t r;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part, default codes (emergency 35, reply 33)
    push_request(build_request(KIND_SEND, 8'd0, 4'd2));     // both rings empty
    r = '{kind: KIND_PACK, src: '1, dst: '1, fc: EMERGENCY_CODE_RST, tot: '1, part: '1,
          obj: '1, och: '1, attr: '1, ach: '1, vals: '1, cnt: 4'd4};
    push_request(r);                                         // all fields at their top
    r = '{kind: KIND_PACK, src: '0, dst: '0, fc: EMERGENCY_CODE_RST, tot: '0, part: '0,
          obj: '0, och: '0, attr: '0, ach: '0, vals: '0, cnt: 4'd2};
    push_request(r);                                         // all fields at zero
    for (int i = 0; i < 6; i++)
      push_request(build_request(KIND_PACK, EMERGENCY_CODE_RST, 4'(2 + i % 3)));
    push_request(build_request(KIND_PACK, EMERGENCY_CODE_RST, 4'd4)); // emergency ring full
    push_request(build_request(KIND_PACK, EMERGENCY_CODE_RST, 4'd1)); // length beats full
    push_request(build_request(KIND_PACK, REPLY_CODE_RST, 4'd1));     // single byte reply
    push_request(build_request(KIND_PACK, 8'd0, 4'd1));               // single byte, not reply
    push_request(build_request(KIND_PACK, 8'd0, 4'd0));
    push_request(build_request(KIND_PACK, 8'd0, 4'd5));
    push_request(build_request(KIND_PACK, 8'd0, 4'd15));
    repeat (10) push_request(build_request(KIND_SEND, 8'd0, 4'd2));   // drain, end empty
    s_axis_tvalid <= 1'b0;

    run_random(90, 40);

    write_code(REG_EMERGENCY_CODE, 8'd0);
    write_code(REG_REPLY_CODE, 8'd255);
    run_random(70, 35);

    // a stretch with no idling on either side
    write_code(REG_EMERGENCY_CODE, 8'd255);
    write_code(REG_REPLY_CODE, 8'd0);
    quiet_run = 1'b1;
    run_random(70, 50);
    quiet_run = 1'b0;

    // reply code equal to emergency code: single byte still rejected there
    write_code(REG_EMERGENCY_CODE, 8'd77);
    write_code(REG_REPLY_CODE, 8'd77);
    run_random(70, 45);

    write_code(REG_EMERGENCY_CODE, 8'($urandom_range(255)));
    write_code(REG_REPLY_CODE, 8'($urandom_range(255)));
    run_random(100, 55);

    while (frame_sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
